FILE: sv/rdm_pkg.sv
package rdm_pkg;

  // Field and datapath widths
  localparam int COORD_W = 32;
  localparam int COEF_W  = 48;
  localparam int TOL_W   = 32;
  localparam int WIDE_W  = 64;
  localparam int PROD_W  = 112;
  localparam int FRAC_W  = 40;
  localparam int HALF_W  = 32;

  // Configuration register indexes
  localparam logic [1:0] CFG_COEF_CONST = 2'd0;
  localparam logic [1:0] CFG_COEF_R2    = 2'd1;
  localparam logic [1:0] CFG_COEF_R4    = 2'd2;
  localparam logic [1:0] CFG_TOLERANCE  = 2'd3;

  // Operation codes
  localparam logic OP_DISTORT   = 1'b0;
  localparam logic OP_UNDISTORT = 1'b1;

  // Constants
  localparam logic [WIDE_W-1:0]        NEAR_CENTRE_Q48 = 64'd281474976;
  localparam logic signed [WIDE_W-1:0] ONE_Q40         = 64'sh0000_0100_0000_0000;
  localparam logic signed [WIDE_W-1:0] S64_MAX         = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [WIDE_W-1:0] S64_MIN         = 64'sh8000_0000_0000_0000;
  localparam logic signed [COORD_W-1:0] S32_MAX        = 32'sh7FFF_FFFF;
  localparam logic signed [COORD_W-1:0] S32_MIN        = 32'sh8000_0000;
  localparam logic [TOL_W-1:0]         TOL_RESET       = 32'd1241;

  // Saturating signed 64-bit add
  function automatic logic signed [WIDE_W-1:0] sat_add64(
    input logic signed [WIDE_W-1:0] a,
    input logic signed [WIDE_W-1:0] b
  );
    logic signed [WIDE_W:0] s;
    s = {a[WIDE_W-1], a} + {b[WIDE_W-1], b};
    if (s[WIDE_W] != s[WIDE_W-1]) begin
      return s[WIDE_W] ? S64_MIN : S64_MAX;
    end
    return s[WIDE_W-1:0];
  endfunction

  // floor(p / 2^40) saturated to signed 64 bits
  function automatic logic signed [WIDE_W-1:0] shr_sat64(
    input logic signed [PROD_W-1:0] p
  );
    logic [PROD_W-1:FRAC_W+WIDE_W-1] top;
    top = p[PROD_W-1:FRAC_W+WIDE_W-1];
    if ((&top) || !(|top)) begin
      return p[FRAC_W+WIDE_W-1:FRAC_W];
    end
    return p[PROD_W-1] ? S64_MIN : S64_MAX;
  endfunction

  // floor(p / 2^40) saturated to signed 32 bits
  function automatic logic signed [COORD_W-1:0] shr_sat32(
    input logic signed [PROD_W-1:0] p
  );
    logic [PROD_W-1:FRAC_W+COORD_W-1] top;
    top = p[PROD_W-1:FRAC_W+COORD_W-1];
    if ((&top) || !(|top)) begin
      return p[FRAC_W+COORD_W-1:FRAC_W];
    end
    return p[PROD_W-1] ? S32_MIN : S32_MAX;
  endfunction

  // Saturate a 33-bit signed value to 32 bits
  function automatic logic signed [COORD_W-1:0] sat32(
    input logic signed [COORD_W:0] v
  );
    if (v[COORD_W] != v[COORD_W-1]) begin
      return v[COORD_W] ? S32_MIN : S32_MAX;
    end
    return v[COORD_W-1:0];
  endfunction

endpackage

FILE: sv/radial_distortion_map.sv
// Every multiply runs on one shared 32x32 unit: an issue state, one to four
//   partial-product steps and a writeback state.
// Distort makes a single pass; undistort makes up to MAX_PASSES passes.
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset: rst_ni clears control state and loads the coefficients to 0 and tolerance to 1241.
module radial_distortion_map #(
  parameter int MAX_PASSES = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [rdm_pkg::COEF_W-1:0]        cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              op_i,
  input  logic signed [rdm_pkg::COORD_W-1:0] x_in_i,
  input  logic signed [rdm_pkg::COORD_W-1:0] y_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [rdm_pkg::COORD_W-1:0] x_out_o,
  output logic signed [rdm_pkg::COORD_W-1:0] y_out_o,
  output logic                              converged_o
);

  localparam int CW     = rdm_pkg::COORD_W;
  localparam int KW     = rdm_pkg::COEF_W;
  localparam int WW     = rdm_pkg::WIDE_W;
  localparam int PW     = rdm_pkg::PROD_W;
  localparam int HW     = rdm_pkg::HALF_W;
  localparam int PASS_W = $clog2(MAX_PASSES + 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ISSUE = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_USE   = 3'd3;
  localparam logic [2:0] ST_BIAS  = 3'd4;
  localparam logic [2:0] ST_CHECK = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  // Multiply steps
  localparam logic [2:0] STEP_SQX = 3'd0;
  localparam logic [2:0] STEP_SQY = 3'd1;
  localparam logic [2:0] STEP_R4  = 3'd2;
  localparam logic [2:0] STEP_K1  = 3'd3;
  localparam logic [2:0] STEP_K2  = 3'd4;
  localparam logic [2:0] STEP_MX  = 3'd5;
  localparam logic [2:0] STEP_MY  = 3'd6;

  // Control and configuration registers
  logic [2:0]              st_q, st_d;
  logic [2:0]              step_q, step_d;
  logic [PASS_W-1:0]       pass_q, pass_d;
  logic                    first_q, first_d;
  logic [1:0]              pk_q, pk_d;
  logic                    out_valid_q, out_valid_d;
  logic signed [KW-1:0]    k0_q, k1_q, k2_q;
  logic [rdm_pkg::TOL_W-1:0] tol_q;

  // Payload registers
  logic                    op_q, op_d;
  logic signed [CW-1:0]    dx_q, dx_d, dy_q, dy_d;
  logic signed [CW-1:0]    ux_q, ux_d, uy_q, uy_d;
  logic signed [CW-1:0]    nx_q, nx_d, ny_q, ny_d;
  logic [WW-1:0]           r2_q, r2_d;
  logic signed [WW-1:0]    r4_q, r4_d, dr_q, dr_d;
  logic [WW-1:0]           ma_q, ma_d, mb_q, mb_d;
  logic                    mneg_q, mneg_d;
  logic signed [PW-1:0]    acc_q, acc_d;
  logic signed [CW-1:0]    fin_x_q, fin_x_d, fin_y_q, fin_y_d;
  logic                    fin_ok_q, fin_ok_d;
  logic signed [CW-1:0]    xo_q, xo_d, yo_q, yo_d;
  logic                    conv_q, conv_d;

  // Datapath signals
  logic signed [WW-1:0]    opa, opb;
  logic [HW-1:0]           ah, bh;
  logic [2*HW-1:0]         pp;
  logic [PW-1:0]           pp_ext;
  logic signed [PW-1:0]    acc_next;
  logic                    hi_a, hi_b;
  logic signed [CW-1:0]    m32;
  logic signed [CW:0]      stx, sty;
  logic [CW:0]             abs_x, abs_y;
  logic                    step_ok;

  assign in_ready_o  = (st_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign x_out_o     = xo_q;
  assign y_out_o     = yo_q;
  assign converged_o = conv_q;

  // Select multiplier operands for the current step
  always_comb begin
    case (step_q)
      STEP_SQX: begin
        opa = {{(WW-CW){ux_q[CW-1]}}, ux_q};
        opb = opa;
      end
      STEP_SQY: begin
        opa = {{(WW-CW){uy_q[CW-1]}}, uy_q};
        opb = opa;
      end
      STEP_R4: begin
        opa = {8'd0, r2_q[WW-1:8]};
        opb = opa;
      end
      STEP_K1: begin
        opa = {{(WW-KW){k1_q[KW-1]}}, k1_q};
        opb = {8'd0, r2_q[WW-1:8]};
      end
      STEP_K2: begin
        opa = {{(WW-KW){k2_q[KW-1]}}, k2_q};
        opb = r4_q;
      end
      STEP_MX: begin
        opa = {{(WW-CW){ux_q[CW-1]}}, ux_q};
        opb = dr_q;
      end
      STEP_MY: begin
        opa = {{(WW-CW){uy_q[CW-1]}}, uy_q};
        opb = dr_q;
      end
      default: begin
        opa = '0;
        opb = '0;
      end
    endcase
  end

  // Partial product of the shared 32x32 unit, placed and accumulated with sign
  always_comb begin
    ah   = pk_q[1] ? ma_q[WW-1:HW] : ma_q[HW-1:0];
    bh   = pk_q[0] ? mb_q[WW-1:HW] : mb_q[HW-1:0];
    pp   = ah * bh;
    hi_a = |ma_q[WW-1:HW];
    hi_b = |mb_q[WW-1:HW];
    case ({1'b0, pk_q[1]} + {1'b0, pk_q[0]})
      2'd0:    pp_ext = {{(PW-2*HW){1'b0}}, pp};
      2'd1:    pp_ext = {{(PW-3*HW){1'b0}}, pp, {HW{1'b0}}};
      2'd2:    pp_ext = {pp[PW-2*HW-1:0], {(2*HW){1'b0}}};
      default: pp_ext = '0;
    endcase
    acc_next = mneg_q ? (acc_q - pp_ext) : (acc_q + pp_ext);
  end

  // Step sizes of the last pass
  always_comb begin
    m32     = rdm_pkg::shr_sat32(acc_q);
    stx     = {nx_q[CW-1], nx_q} - {ux_q[CW-1], ux_q};
    sty     = {ny_q[CW-1], ny_q} - {uy_q[CW-1], uy_q};
    abs_x   = stx[CW] ? (~stx + 1'b1) : stx;
    abs_y   = sty[CW] ? (~sty + 1'b1) : sty;
    step_ok = (abs_x < {1'b0, tol_q}) && (abs_y < {1'b0, tol_q});
  end

  // Sequencer
  always_comb begin
    st_d        = st_q;
    step_d      = step_q;
    pass_d      = pass_q;
    first_d     = first_q;
    pk_d        = pk_q;
    op_d        = op_q;
    dx_d        = dx_q;
    dy_d        = dy_q;
    ux_d        = ux_q;
    uy_d        = uy_q;
    nx_d        = nx_q;
    ny_d        = ny_q;
    r2_d        = r2_q;
    r4_d        = r4_q;
    dr_d        = dr_q;
    ma_d        = ma_q;
    mb_d        = mb_q;
    mneg_d      = mneg_q;
    acc_d       = acc_q;
    fin_x_d     = fin_x_q;
    fin_y_d     = fin_y_q;
    fin_ok_d    = fin_ok_q;
    xo_d        = xo_q;
    yo_d        = yo_q;
    conv_d      = conv_q;
    out_valid_d = out_valid_q && !out_ready_i;

    case (st_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          op_d    = op_i;
          dx_d    = x_in_i;
          dy_d    = y_in_i;
          ux_d    = x_in_i;
          uy_d    = y_in_i;
          pass_d  = '0;
          first_d = 1'b1;
          step_d  = STEP_SQX;
          st_d    = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (step_q == STEP_R4 && first_q && r2_q <= rdm_pkg::NEAR_CENTRE_Q48) begin
          // near the centre: pass the point through
          fin_x_d  = dx_q;
          fin_y_d  = dy_q;
          fin_ok_d = 1'b1;
          st_d     = ST_DONE;
        end else begin
          ma_d   = opa[WW-1] ? (~opa + 1'b1) : opa;
          mb_d   = opb[WW-1] ? (~opb + 1'b1) : opb;
          mneg_d = opa[WW-1] ^ opb[WW-1];
          acc_d  = '0;
          pk_d   = 2'd0;
          st_d   = ST_MUL;
        end
      end
      ST_MUL: begin
        // skip partial products whose high halves are zero
        acc_d = acc_next;
        case (pk_q)
          2'd0: begin
            if (hi_b) begin
              pk_d = 2'd1;
            end else if (hi_a) begin
              pk_d = 2'd2;
            end else begin
              st_d = ST_USE;
            end
          end
          2'd1: begin
            if (hi_a) begin
              pk_d = 2'd2;
            end else begin
              st_d = ST_USE;
            end
          end
          2'd2: begin
            if (hi_b) begin
              pk_d = 2'd3;
            end else begin
              st_d = ST_USE;
            end
          end
          default: st_d = ST_USE;
        endcase
      end
      ST_USE: begin
        st_d = ST_ISSUE;
        case (step_q)
          STEP_SQX: begin
            r2_d   = acc_q[WW-1:0];
            step_d = STEP_SQY;
          end
          STEP_SQY: begin
            r2_d   = r2_q + acc_q[WW-1:0];
            step_d = STEP_R4;
          end
          STEP_R4: begin
            r4_d   = rdm_pkg::shr_sat64(acc_q);
            step_d = STEP_K1;
          end
          STEP_K1: begin
            dr_d   = rdm_pkg::sat_add64({{(WW-KW){k0_q[KW-1]}}, k0_q},
                                        rdm_pkg::shr_sat64(acc_q));
            step_d = STEP_K2;
          end
          STEP_K2: begin
            dr_d   = rdm_pkg::sat_add64(dr_q, rdm_pkg::shr_sat64(acc_q));
            step_d = STEP_MX;
            if (op_q == rdm_pkg::OP_DISTORT) begin
              st_d = ST_BIAS;
            end
          end
          STEP_MX: begin
            if (op_q == rdm_pkg::OP_DISTORT) begin
              nx_d = m32;
            end else begin
              nx_d = rdm_pkg::sat32({dx_q[CW-1], dx_q} - {m32[CW-1], m32});
            end
            step_d = STEP_MY;
          end
          STEP_MY: begin
            if (op_q == rdm_pkg::OP_DISTORT) begin
              fin_x_d  = nx_q;
              fin_y_d  = m32;
              fin_ok_d = 1'b1;
              st_d     = ST_DONE;
            end else begin
              ny_d = rdm_pkg::sat32({dy_q[CW-1], dy_q} - {m32[CW-1], m32});
              st_d = ST_CHECK;
            end
          end
          default: st_d = ST_IDLE;
        endcase
      end
      ST_BIAS: begin
        // add 1.0 for the forward map
        dr_d = rdm_pkg::sat_add64(rdm_pkg::ONE_Q40, dr_q);
        st_d = ST_ISSUE;
      end
      ST_CHECK: begin
        ux_d = nx_q;
        uy_d = ny_q;
        if (step_ok) begin
          fin_x_d  = nx_q;
          fin_y_d  = ny_q;
          fin_ok_d = 1'b1;
          st_d     = ST_DONE;
        end else if (pass_q == PASS_W'(MAX_PASSES - 1)) begin
          // out of passes: return the input
          fin_x_d  = dx_q;
          fin_y_d  = dy_q;
          fin_ok_d = 1'b0;
          st_d     = ST_DONE;
        end else begin
          pass_d  = pass_q + PASS_W'(1);
          first_d = 1'b0;
          step_d  = STEP_SQX;
          st_d    = ST_ISSUE;
        end
      end
      ST_DONE: begin
        // hand the result to the output register once it is free
        if (!out_valid_q || out_ready_i) begin
          xo_d        = fin_x_q;
          yo_d        = fin_y_q;
          conv_d      = fin_ok_q;
          out_valid_d = 1'b1;
          st_d        = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  // Control and configuration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      step_q      <= STEP_SQX;
      pass_q      <= '0;
      first_q     <= 1'b0;
      pk_q        <= 2'd0;
      out_valid_q <= 1'b0;
      k0_q        <= '0;
      k1_q        <= '0;
      k2_q        <= '0;
      tol_q       <= rdm_pkg::TOL_RESET;
    end else begin
      st_q        <= st_d;
      step_q      <= step_d;
      pass_q      <= pass_d;
      first_q     <= first_d;
      pk_q        <= pk_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rdm_pkg::CFG_COEF_CONST: k0_q  <= cfg_data_i;
          rdm_pkg::CFG_COEF_R2:    k1_q  <= cfg_data_i;
          rdm_pkg::CFG_COEF_R4:    k2_q  <= cfg_data_i;
          rdm_pkg::CFG_TOLERANCE:  tol_q <= cfg_data_i[rdm_pkg::TOL_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload state
  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    dx_q     <= dx_d;
    dy_q     <= dy_d;
    ux_q     <= ux_d;
    uy_q     <= uy_d;
    nx_q     <= nx_d;
    ny_q     <= ny_d;
    r2_q     <= r2_d;
    r4_q     <= r4_d;
    dr_q     <= dr_d;
    ma_q     <= ma_d;
    mb_q     <= mb_d;
    mneg_q   <= mneg_d;
    acc_q    <= acc_d;
    fin_x_q  <= fin_x_d;
    fin_y_q  <= fin_y_d;
    fin_ok_q <= fin_ok_d;
    xo_q     <= xo_d;
    yo_q     <= yo_d;
    conv_q   <= conv_d;
  end

`ifndef NO_ASSERTIONS
  a_pass_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q != ST_IDLE) |-> (pass_q <= PASS_W'(MAX_PASSES - 1)))
    else $error("pass counter beyond last pass");

  a_pp_top: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_MUL && pk_q == 2'd3) |-> (hi_a && hi_b))
    else $error("high partial product issued with a zero half");

  a_fail_undist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DONE && !fin_ok_q) |-> (op_q == rdm_pkg::OP_UNDISTORT))
    else $error("forward map reported no convergence");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (st_q == ST_ISSUE && step_q == STEP_SQX))
    else $error("item transfer did not start the radius step");

  a_square_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_USE && (step_q == STEP_SQX || step_q == STEP_SQY)) |-> !acc_q[PW-1])
    else $error("negative square");
`endif

endmodule
